// ===== design/rttip_pkg.sv =====
// ----------------------------------------------------------------------------
// rttip_pkg
// Shared types and constants for the radix text-to-integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rttip_pkg;

  localparam int CHAR_W          = 8;
  localparam int NUMBER_W        = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_SEL_W     = 2;
  localparam int DIGIT_W         = 4;

  // radix_select codes
  localparam logic [RADIX_SEL_W-1:0] RADIX_BIN = 2'd0;
  localparam logic [RADIX_SEL_W-1:0] RADIX_OCT = 2'd1;
  localparam logic [RADIX_SEL_W-1:0] RADIX_DEC = 2'd2;
  localparam logic [RADIX_SEL_W-1:0] RADIX_HEX = 2'd3;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

  typedef struct packed {
    logic               blank;
    logic               minus;
    logic               plus;
    logic               digit_ok;
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic                parse_ok;
    logic [NUMBER_W-1:0] number;
  } parse_result_t;

endpackage

`default_nettype wire

// ===== design/rttip_classify.sv =====
// ----------------------------------------------------------------------------
// rttip_classify
// Character decode: whitespace, sign, and digit value checked against radix.
// ----------------------------------------------------------------------------
`default_nettype none

module rttip_classify (
  input  wire logic [rttip_pkg::CHAR_W-1:0]      char_code,
  input  wire logic [rttip_pkg::RADIX_SEL_W-1:0] radix_select,
  output rttip_pkg::char_class_t                 cls
);
  import rttip_pkg::*;

  logic [CHAR_W-1:0]  off_num;
  logic [CHAR_W-1:0]  off_upper;
  logic [CHAR_W-1:0]  off_lower;
  logic               raw_ok;
  logic [DIGIT_W-1:0] raw_digit;
  logic               in_radix;

  assign off_num   = char_code - CH_0;
  assign off_upper = char_code - CH_UA;
  assign off_lower = char_code - CH_LA;

  always_comb begin
    raw_ok    = 1'b1;
    raw_digit = '0;
    if (char_code >= CH_0 && char_code <= CH_9) begin
      raw_digit = off_num[DIGIT_W-1:0];
    end else if (char_code >= CH_UA && char_code <= CH_UF) begin
      raw_digit = off_upper[DIGIT_W-1:0] + HEX_LETTER_BASE;
    end else if (char_code >= CH_LA && char_code <= CH_LF) begin
      raw_digit = off_lower[DIGIT_W-1:0] + HEX_LETTER_BASE;
    end else begin
      raw_ok = 1'b0;
    end
  end

  always_comb begin
    unique case (radix_select)
      RADIX_BIN: in_radix = (raw_digit < 4'd2);
      RADIX_OCT: in_radix = (raw_digit < 4'd8);
      RADIX_DEC: in_radix = (raw_digit < 4'd10);
      RADIX_HEX: in_radix = 1'b1;
      default:   in_radix = 1'b0;
    endcase
  end

  assign cls.blank    = (char_code == CH_SPACE) ||
                        (char_code >= CH_TAB && char_code <= CH_CR);
  assign cls.minus    = (char_code == CH_MINUS);
  assign cls.plus     = (char_code == CH_PLUS);
  assign cls.digit_ok = raw_ok && in_radix;
  assign cls.digit    = raw_digit;

endmodule

`default_nettype wire

// ===== design/rttip_core.sv =====
// ----------------------------------------------------------------------------
// rttip_core
// Parse state (phase, sign, accumulator) and per-character update.
// ----------------------------------------------------------------------------
`default_nettype none

module rttip_core #(
  parameter int VALUE_WIDTH = rttip_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step_en,
  input  wire logic                              is_last,
  input  wire logic [rttip_pkg::RADIX_SEL_W-1:0] radix_select,
  input  wire rttip_pkg::char_class_t            cls,
  output rttip_pkg::parse_result_t               result
);
  import rttip_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_TRAIL,
    PH_ERROR
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;
  logic [VALUE_WIDTH-1:0] acc_scaled;
  logic [VALUE_WIDTH-1:0] digit_ext;
  logic [VALUE_WIDTH-1:0] signed_val;
  logic [NUMBER_W-1:0]    num_ext;

  assign digit_ext = VALUE_WIDTH'(cls.digit);

  // radix multiply as shifts; decimal is x8 + x2
  always_comb begin
    unique case (radix_select)
      RADIX_BIN: acc_scaled = accumulator << 1;
      RADIX_OCT: acc_scaled = accumulator << 3;
      RADIX_DEC: acc_scaled = (accumulator << 3) + (accumulator << 1);
      RADIX_HEX: acc_scaled = accumulator << 4;
      default:   acc_scaled = '0;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    unique case (phase)
      PH_LEAD: begin
        priority if (cls.blank) begin
          phase_next = PH_LEAD;
        end else if (cls.minus) begin
          negative_next = 1'b1;
          phase_next    = PH_DIGITS;
        end else if (cls.plus) begin
          phase_next = PH_DIGITS;
        end else if (cls.digit_ok) begin
          accumulator_next = digit_ext;
          phase_next       = PH_DIGITS;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        priority if (cls.digit_ok) begin
          accumulator_next = acc_scaled + digit_ext;
        end else if (cls.blank) begin
          phase_next = PH_TRAIL;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_TRAIL: begin
        if (!cls.blank) begin
          phase_next = PH_ERROR;
        end
      end
      PH_ERROR: phase_next = PH_ERROR;
      default:  phase_next = PH_ERROR;
    endcase
  end

  assign signed_val = negative_next ? (VALUE_WIDTH'(0) - accumulator_next)
                                    : accumulator_next;

  generate
    if (VALUE_WIDTH >= NUMBER_W) begin : g_trunc
      assign num_ext = signed_val[NUMBER_W-1:0];
    end else begin : g_sext
      assign num_ext = {{(NUMBER_W-VALUE_WIDTH){signed_val[VALUE_WIDTH-1]}}, signed_val};
    end
  endgenerate

  assign result.parse_ok = (phase_next != PH_ERROR);
  assign result.number   = (phase_next != PH_ERROR) ? num_ext : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (step_en) begin
      if (is_last) begin
        // field done: back to the start for the next one
        phase       <= PH_LEAD;
        negative    <= 1'b0;
        accumulator <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/radix_text_to_integer_parser.sv =====
// ----------------------------------------------------------------------------
// radix_text_to_integer_parser
// Streaming strtol-style parser: characters in, one signed integer per field.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one character per item; s_tlast marks the final character of
//   a field. For each field one item leaves on m_*: m_tuser is the ok flag,
//   m_tdata the 32-bit signed value (zero when not ok). Other characters
//   produce no output item.
//   cfg_we/cfg_wdata set the radix (0 bin, 1 oct, 2 dec, 3 hex); change it
//   only while the block is idle.
// Timing:
//   Input register -> decode and state update -> result register. The result
//   register (m_tvalid) is set as the last character leaves the input
//   register; one character is taken every cycle unless a stall holds it. The
//   accumulator update (shift-add by radix plus digit) is combinational.
// Reset:
//   rst (synchronous) empties both registers, clears the parse state and sets
//   the radix to decimal.
// Stall:
//   While m_tready is low a held result blocks only the next last character;
//   other characters keep flowing until that one reaches the core.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_text_to_integer_parser #(
  parameter int VALUE_WIDTH = rttip_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rttip_pkg::RADIX_SEL_W-1:0] cfg_wdata,     // radix_select
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [rttip_pkg::CHAR_W-1:0]      s_tdata,       // [7:0] char_code
  input  wire logic                              s_tlast,       // is_last
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [rttip_pkg::NUMBER_W-1:0]    m_tdata,       // [31:0] number
  output      logic                              m_tuser        // [0] parse_ok
);
  import rttip_pkg::*;

  logic [RADIX_SEL_W-1:0] radix_select;
  logic                   in_valid;
  logic [CHAR_W-1:0]      in_char;
  logic                   in_last;
  logic                   step_en;
  char_class_t            cls;
  parse_result_t          result;

  // a last char needs a free result slot; others always advance
  assign step_en  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_select <= RADIX_DEC;
    end else if (cfg_we) begin
      radix_select <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  rttip_classify u_classify (
    .char_code    (in_char),
    .radix_select (radix_select),
    .cls          (cls)
  );

  rttip_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_en),
    .is_last      (in_last),
    .radix_select (radix_select),
    .cls          (cls),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_en && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && in_last) begin
      m_tuser <= result.parse_ok;
      m_tdata <= result.number;
    end
  end

endmodule

`default_nettype wire
